// ===== hdl/e2h_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2h_pkg
// shared types, constants and arithmetic helpers for the equatorial to
// horizontal coordinate converter
// ----------------------------------------------------------------------------
package e2h_pkg;

    localparam int ANGLE_BITS_DEF    = 32;
    localparam int CORDIC_STAGES_DEF = 32;

    localparam logic signed [31:0] Q30_ONE         = 32'sd1073741824;
    localparam logic signed [31:0] CORDIC_INV_GAIN = 32'sd652032874;
    localparam logic [63:0]        INV_TWO_PI_Q64  = 64'h28BE60DB9391054A;

    typedef enum logic [1:0] {
        CFG_SOURCE_RA    = 2'd0,
        CFG_SOURCE_DEC   = 2'd1,
        CFG_SITE_SIN_LAT = 2'd2,
        CFG_SITE_COS_LAT = 2'd3
    } t_cfg_idx;

    // spherical trigonometry terms
    typedef struct packed {
        logic signed [31:0] cec_az;
        logic signed [31:0] ces_az;
        logic signed [31:0] ces_pa;
        logic signed [31:0] cec_pa;
        logic signed [31:0] sin_el;
    } t_terms;

    // arctangent of 2^-i as a fraction of a turn, rounded to bits
    function automatic logic [63:0] atan_entry(input int i, input int bits);
        logic [63:0]  rad;
        logic [63:0]  turns;
        logic [63:0]  t;
        logic [127:0] prod;
        int           k;
        int           n;
        rad = '0;
        if (i == 0) begin
            turns = 64'd1 << 61;
        end else begin
            for (k = 0; i * (2 * k + 1) < 64; k++) begin
                n = i * (2 * k + 1);
                t = (64'd1 << (64 - n)) / 64'(2 * k + 1);
                if (k[0]) begin
                    rad = rad - t;
                end else begin
                    rad = rad + t;
                end
            end
            prod  = {64'd0, rad} * {64'd0, INV_TWO_PI_Q64};
            turns = prod[127:64];
        end
        return (turns + (64'd1 << (63 - bits))) >> (64 - bits);
    endfunction

    // q2.30 product, halves rounded away from zero
    function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic signed [67:0] p;
        logic [67:0]        m;
        logic [67:0]        r;
        logic signed [33:0] rr;
        p  = a * b;
        m  = p[67] ? 68'(-p) : 68'(p);
        r  = (m + 68'(1 << 29)) >> 30;
        rr = 34'(r);
        return p[67] ? -rr : rr;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] satq30(input logic signed [33:0] v);
        if (v > 34'(Q30_ONE)) begin
            return Q30_ONE;
        end else if (v < -34'(Q30_ONE)) begin
            return -Q30_ONE;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/e2h_rot.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2h_rot
// pipelined rotation-mode cordic: sine and cosine of a binary angle, one
// iteration per stage, sideband tag carried alongside
// ----------------------------------------------------------------------------
module e2h_rot #(
    parameter int A  = e2h_pkg::ANGLE_BITS_DEF,
    parameter int N  = e2h_pkg::CORDIC_STAGES_DEF,
    parameter int TW = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_vld,
    input  wire logic [A-1:0]         i_ang,
    input  wire logic [TW-1:0]        i_tag,
    output logic                      o_vld,
    output logic signed [31:0]        o_sin,
    output logic signed [31:0]        o_cos,
    output logic [TW-1:0]             o_tag
);
    localparam int ZW = A + 2;
    localparam int XW = 36;
    localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (A - 2);
    localparam logic signed [ZW-1:0] HALF    = ZW'(1) <<< (A - 1);
    localparam logic signed [XW-1:0] ONE     = XW'(e2h_pkg::Q30_ONE);

    logic signed [XW-1:0] r_x [0:N];
    logic signed [XW-1:0] r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    logic [N:0]           r_neg;
    logic [TW-1:0]        r_tag [0:N];
    logic [N:0]           r_vld;
    logic                 r_ovld;

    logic signed [ZW-1:0] n_z0;
    logic                 n_neg0;
    logic signed [XW-1:0] n_c;
    logic signed [XW-1:0] n_s;

    // fold into plus or minus a quarter turn
    always_comb begin
        n_z0   = ZW'($signed(i_ang));
        n_neg0 = 1'b0;
        if (n_z0 > QUARTER) begin
            n_z0   = n_z0 - HALF;
            n_neg0 = 1'b1;
        end else if (n_z0 < -QUARTER) begin
            n_z0   = n_z0 + HALF;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= XW'(e2h_pkg::CORDIC_INV_GAIN);
            r_y[0]   <= '0;
            r_z[0]   <= n_z0;
            r_neg[0] <= n_neg0;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_it
        localparam logic signed [ZW-1:0] TAB = ZW'(e2h_pkg::atan_entry(i, A));
        logic signed [XW-1:0] n_x;
        logic signed [XW-1:0] n_y;
        logic signed [ZW-1:0] n_z;
        always_comb begin
            if (r_z[i] >= 0) begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - TAB;
            end else begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + TAB;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]   <= n_x;
                r_y[i+1]   <= n_y;
                r_z[i+1]   <= n_z;
                r_neg[i+1] <= r_neg[i];
                r_tag[i+1] <= r_tag[i];
            end
        end
    end

    assign n_c = r_neg[N] ? -r_x[N] : r_x[N];
    assign n_s = r_neg[N] ? -r_y[N] : r_y[N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= (n_c > ONE) ? e2h_pkg::Q30_ONE :
                     (n_c < -ONE) ? -e2h_pkg::Q30_ONE : n_c[31:0];
            o_sin <= (n_s > ONE) ? e2h_pkg::Q30_ONE :
                     (n_s < -ONE) ? -e2h_pkg::Q30_ONE : n_s[31:0];
            o_tag <= r_tag[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_vld  <= {r_vld[N-1:0], i_vld};
            r_ovld <= r_vld[N];
        end
    end

    assign o_vld = r_ovld;

endmodule
`default_nettype wire

// ===== hdl/e2h_vec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2h_vec
// pipelined vectoring-mode cordic: atan2 of a q2.30 pair as a binary angle,
// one iteration per stage, sideband tag carried alongside
// ----------------------------------------------------------------------------
module e2h_vec #(
    parameter int A  = e2h_pkg::ANGLE_BITS_DEF,
    parameter int N  = e2h_pkg::CORDIC_STAGES_DEF,
    parameter int TW = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_vld,
    input  wire logic signed [31:0]   i_y,
    input  wire logic signed [31:0]   i_x,
    input  wire logic [TW-1:0]        i_tag,
    output logic                      o_vld,
    output logic [A-1:0]              o_ang,
    output logic [TW-1:0]             o_tag
);
    localparam int ZW = A + 2;
    localparam int XW = 51;
    localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (A - 1);

    logic signed [XW-1:0] r_x [0:N];
    logic signed [XW-1:0] r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    logic [TW-1:0]        r_tag [0:N];
    logic [N:0]           r_vld;

    logic signed [XW-1:0] n_px;
    logic signed [XW-1:0] n_py;

    assign n_px = XW'(i_x) <<< 16;
    assign n_py = XW'(i_y) <<< 16;

    // fold into the right half plane
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_px < 0) begin
                r_x[0] <= -n_px;
                r_y[0] <= -n_py;
                r_z[0] <= HALF;
            end else begin
                r_x[0] <= n_px;
                r_y[0] <= n_py;
                r_z[0] <= '0;
            end
            r_tag[0] <= i_tag;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_it
        localparam logic signed [ZW-1:0] TAB = ZW'(e2h_pkg::atan_entry(i, A));
        logic signed [XW-1:0] n_x;
        logic signed [XW-1:0] n_y;
        logic signed [ZW-1:0] n_z;
        always_comb begin
            if (r_y[i] >= 0) begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + TAB;
            end else begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - TAB;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]   <= n_x;
                r_y[i+1]   <= n_y;
                r_z[i+1]   <= n_z;
                r_tag[i+1] <= r_tag[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-1:0], i_vld};
        end
    end

    assign o_vld = r_vld[N];
    assign o_ang = r_z[N][A-1:0];
    assign o_tag = r_tag[N];

endmodule
`default_nettype wire

// ===== hdl/e2h_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2h_sqrt
// pipelined digit-by-digit square root of a 64-bit radicand, one result bit
// per stage, rounded to nearest
// ----------------------------------------------------------------------------
module e2h_sqrt #(
    parameter int TW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [63:0]   i_rad,
    input  wire logic [TW-1:0] i_tag,
    output logic               o_vld,
    output logic [32:0]        o_root,
    output logic [TW-1:0]      o_tag
);
    localparam int S = 32;

    logic [63:0]   r_rem [0:S];
    logic [63:0]   r_res [0:S];
    logic [TW-1:0] r_tag [0:S];
    logic [S:0]    r_vld;
    logic          r_ovld;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_rad;
            r_res[0] <= '0;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar i = 0; i < S; i++) begin : g_it
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [64:0] n_trial;
        assign n_trial = {1'b0, r_res[i]} + {1'b0, BIT};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, r_rem[i]} >= n_trial) begin
                    r_rem[i+1] <= r_rem[i] - n_trial[63:0];
                    r_res[i+1] <= (r_res[i] >> 1) + BIT;
                end else begin
                    r_rem[i+1] <= r_rem[i];
                    r_res[i+1] <= r_res[i] >> 1;
                end
                r_tag[i+1] <= r_tag[i];
            end
        end
    end

    // remainder equals radicand minus root squared
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_root <= 33'(r_res[S]) + 33'(r_rem[S] > r_res[S]);
            o_tag  <= r_tag[S];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_vld  <= {r_vld[S-1:0], i_vld};
            r_ovld <= r_vld[S];
        end
    end

    assign o_vld = r_ovld;

endmodule
`default_nettype wire

// ===== hdl/e2h_mix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2h_mix
// spherical trigonometry products, saturation and the squared terms for
// the two square roots, five register stages
// ----------------------------------------------------------------------------
module e2h_mix (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_vld,
    input  wire logic signed [31:0]   i_sin_ha,
    input  wire logic signed [31:0]   i_cos_ha,
    input  wire logic signed [31:0]   i_sin_dec,
    input  wire logic signed [31:0]   i_cos_dec,
    input  wire logic signed [31:0]   i_sin_lat,
    input  wire logic signed [31:0]   i_cos_lat,
    output logic                      o_vld,
    output e2h_pkg::t_terms           o_terms,
    output logic [63:0]               o_rad_cos,
    output logic [63:0]               o_rad_c
);
    logic [4:0] r_vld;

    // stage 1
    logic signed [33:0] r_sd_cl, r_cd_sl, r_cd_sh, r_sh_cl, r_sd_sl, r_cd_cl;
    logic signed [31:0] r_cos_ha;
    // stage 2
    logic signed [33:0] r2_sd_cl, r2_cd_sl, r2_cd_sh, r2_sh_cl, r2_sd_sl;
    logic signed [33:0] r_t1, r_t2, r_t3;
    // stage 3
    e2h_pkg::t_terms    r3_terms;
    // stage 4
    e2h_pkg::t_terms    r4_terms;
    logic [63:0]        r_sq_a, r_sq_b, r_sq_s;

    logic [31:0] n_ma;
    logic [31:0] n_mb;
    logic [31:0] n_ms;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd_cl  <= e2h_pkg::mulq(34'(i_sin_dec), 34'(i_cos_lat));
            r_cd_sl  <= e2h_pkg::mulq(34'(i_cos_dec), 34'(i_sin_lat));
            r_cd_sh  <= e2h_pkg::mulq(34'(i_cos_dec), 34'(i_sin_ha));
            r_sh_cl  <= e2h_pkg::mulq(34'(i_sin_ha), 34'(i_cos_lat));
            r_sd_sl  <= e2h_pkg::mulq(34'(i_sin_dec), 34'(i_sin_lat));
            r_cd_cl  <= e2h_pkg::mulq(34'(i_cos_dec), 34'(i_cos_lat));
            r_cos_ha <= i_cos_ha;

            r_t1     <= e2h_pkg::mulq(r_cd_sl, 34'(r_cos_ha));
            r_t2     <= e2h_pkg::mulq(r_sd_cl, 34'(r_cos_ha));
            r_t3     <= e2h_pkg::mulq(r_cd_cl, 34'(r_cos_ha));
            r2_sd_cl <= r_sd_cl;
            r2_cd_sl <= r_cd_sl;
            r2_cd_sh <= r_cd_sh;
            r2_sh_cl <= r_sh_cl;
            r2_sd_sl <= r_sd_sl;

            r3_terms.cec_az <= e2h_pkg::sat32(r2_sd_cl - r_t1);
            r3_terms.ces_az <= e2h_pkg::sat32(-r2_cd_sh);
            r3_terms.ces_pa <= e2h_pkg::sat32(r2_sh_cl);
            r3_terms.cec_pa <= e2h_pkg::sat32(r2_cd_sl - r_t2);
            r3_terms.sin_el <= e2h_pkg::satq30(r2_sd_sl + r_t3);

            r4_terms <= r3_terms;
            r_sq_a   <= 64'(n_ma) * 64'(n_ma);
            r_sq_b   <= 64'(n_mb) * 64'(n_mb);
            r_sq_s   <= 64'(n_ms) * 64'(n_ms);

            o_terms   <= r4_terms;
            o_rad_cos <= r_sq_a + r_sq_b;
            o_rad_c   <= (64'd1 << 60) - r_sq_s;
        end
    end

    assign n_ma = r3_terms.cec_az[31] ? 32'(-r3_terms.cec_az) : 32'(r3_terms.cec_az);
    assign n_mb = r3_terms.ces_az[31] ? 32'(-r3_terms.ces_az) : 32'(r3_terms.ces_az);
    assign n_ms = r3_terms.sin_el[31] ? 32'(-r3_terms.sin_el) : 32'(r3_terms.sin_el);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    assign o_vld = r_vld[4];

endmodule
`default_nettype wire

// ===== hdl/equatorial_to_horizon.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// equatorial_to_horizon
// equatorial to horizontal coordinate conversion of one sidereal time per
// transaction: azimuth, elevation, parallactic angle and az/el trigonometry
// ----------------------------------------------------------------------------
// One transaction enters per clock while the pipeline advances, and results
// leave in order through a rotation cordic for the hour angle and
// declination, five product stages, a 34-stage square root, a vectoring
// cordic for the three angles and a rotation cordic for the azimuth
// trigonometry, then the output register. The whole pipeline advances
// whenever the output register is empty or being taken, so the throughput
// is one transaction per cycle while the sink keeps up. The user must write
// configuration registers only while no transaction is in flight; the
// block itself does not enforce this.
module equatorial_to_horizon #(
    parameter int ANGLE_BITS    = e2h_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = e2h_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [31:0]          i_sidereal_time,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [31:0]               o_azimuth,
    output logic signed [31:0]        o_elevation,
    output logic signed [31:0]        o_parallactic,
    output logic signed [31:0]        o_sine_az,
    output logic signed [31:0]        o_cosine_az,
    output logic signed [31:0]        o_sine_el,
    output logic signed [31:0]        o_cosine_el
);
    localparam int A   = ANGLE_BITS;
    localparam int N   = CORDIC_STAGES;
    localparam int FTW = 3 * A + 64;
    localparam logic [A-1:0] OUT_HALF =
        (A > 32) ? (A'(1) << ((A > 32) ? A - 33 : 0)) : '0;

    logic [31:0]        r_source_ra;
    logic [31:0]        r_source_dec;
    logic signed [31:0] r_site_sin_lat;
    logic signed [31:0] r_site_cos_lat;
    logic               r_out_vld;
    logic               en;

    // binary angle to the internal angle width
    function automatic logic [A-1:0] angle_in(input logic [31:0] a);
        logic [A+31:0] w;
        w = {a, A'(0)};
        return w[A+31 -: A];
    endfunction

    // internal angle to 32 bits, halves rounded up
    function automatic logic [31:0] angle_out(input logic [A-1:0] a);
        logic [A-1:0]  s;
        logic [A+31:0] w;
        s = a + OUT_HALF;
        w = {s, 32'd0};
        return w[A+31 -: 32];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_ra    <= '0;
            r_source_dec   <= '0;
            r_site_sin_lat <= '0;
            r_site_cos_lat <= e2h_pkg::Q30_ONE;
        end else if (i_cfg_we) begin
            case (e2h_pkg::t_cfg_idx'(i_cfg_idx))
                e2h_pkg::CFG_SOURCE_RA:    r_source_ra    <= i_cfg_data;
                e2h_pkg::CFG_SOURCE_DEC:   r_source_dec   <= i_cfg_data;
                e2h_pkg::CFG_SITE_SIN_LAT: r_site_sin_lat <= i_cfg_data;
                e2h_pkg::CFG_SITE_COS_LAT: r_site_cos_lat <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    // hour angle and declination trigonometry
    logic               ha_vld, dec_vld, dec_tag;
    logic signed [31:0] sin_ha, cos_ha, sin_dec, cos_dec;
    logic               ha_tag;

    e2h_rot #(.A(A), .N(N), .TW(1)) u_rot_ha (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_in_valid),
        .i_ang(angle_in(i_sidereal_time - r_source_ra)), .i_tag(i_in_valid),
        .o_vld(ha_vld), .o_sin(sin_ha), .o_cos(cos_ha), .o_tag(ha_tag)
    );

    e2h_rot #(.A(A), .N(N), .TW(1)) u_rot_dec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(i_in_valid),
        .i_ang(angle_in(r_source_dec)), .i_tag(i_in_valid),
        .o_vld(dec_vld), .o_sin(sin_dec), .o_cos(cos_dec), .o_tag(dec_tag)
    );

    // products and squared terms
    logic            mix_vld;
    e2h_pkg::t_terms mix_terms;
    logic [63:0]     rad_cos, rad_c;

    e2h_mix u_mix (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(ha_vld & dec_vld & ha_tag & dec_tag),
        .i_sin_ha(sin_ha), .i_cos_ha(cos_ha),
        .i_sin_dec(sin_dec), .i_cos_dec(cos_dec),
        .i_sin_lat(r_site_sin_lat), .i_cos_lat(r_site_cos_lat),
        .o_vld(mix_vld), .o_terms(mix_terms),
        .o_rad_cos(rad_cos), .o_rad_c(rad_c)
    );

    // square roots
    logic            sq1_vld, sq2_vld;
    logic [32:0]     root_cos, root_c;
    e2h_pkg::t_terms sq_terms;
    logic [31:0]     sq_sin_el;

    e2h_sqrt #(.TW($bits(e2h_pkg::t_terms))) u_sqrt_cos (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(mix_vld),
        .i_rad(rad_cos), .i_tag(mix_terms),
        .o_vld(sq1_vld), .o_root(root_cos), .o_tag(sq_terms)
    );

    e2h_sqrt #(.TW(32)) u_sqrt_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(mix_vld),
        .i_rad(rad_c), .i_tag(mix_terms.sin_el),
        .o_vld(sq2_vld), .o_root(root_c), .o_tag(sq_sin_el)
    );

    logic               sq_vld, deg_az, deg_pa;
    logic signed [31:0] cos_el;

    assign sq_vld = sq1_vld & sq2_vld;
    assign deg_az = (sq_terms.cec_az == '0) && (sq_terms.ces_az == '0);
    assign deg_pa = (sq_terms.cec_pa == '0) && (sq_terms.ces_pa == '0);
    assign cos_el = (root_cos > 33'(e2h_pkg::Q30_ONE)) ? e2h_pkg::Q30_ONE
                                                       : root_cos[31:0];

    // angles
    logic         el_vld, az_vld, pa_vld, az_deg, pa_deg;
    logic [A-1:0] el_ang, az_ang, pa_ang, az_sel, pa_sel;
    logic [63:0]  el_tag;

    e2h_vec #(.A(A), .N(N), .TW(64)) u_vec_el (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(sq_vld),
        .i_y(sq_sin_el), .i_x(root_c[31:0]), .i_tag({sq_sin_el, cos_el}),
        .o_vld(el_vld), .o_ang(el_ang), .o_tag(el_tag)
    );

    e2h_vec #(.A(A), .N(N), .TW(1)) u_vec_az (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(sq_vld),
        .i_y(sq_terms.ces_az), .i_x(sq_terms.cec_az), .i_tag(deg_az),
        .o_vld(az_vld), .o_ang(az_ang), .o_tag(az_deg)
    );

    e2h_vec #(.A(A), .N(N), .TW(1)) u_vec_pa (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(sq_vld),
        .i_y(sq_terms.ces_pa), .i_x(sq_terms.cec_pa), .i_tag(deg_pa),
        .o_vld(pa_vld), .o_ang(pa_ang), .o_tag(pa_deg)
    );

    assign az_sel = az_deg ? '0 : az_ang;
    assign pa_sel = pa_deg ? '0 : pa_ang;

    // azimuth trigonometry
    logic               fin_vld;
    logic signed [31:0] sin_az, cos_az;
    logic [FTW-1:0]     fin_tag;

    e2h_rot #(.A(A), .N(N), .TW(FTW)) u_rot_az (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(el_vld & az_vld & pa_vld),
        .i_ang(az_sel), .i_tag({az_sel, el_ang, pa_sel, el_tag}),
        .o_vld(fin_vld), .o_sin(sin_az), .o_cos(cos_az), .o_tag(fin_tag)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_azimuth     <= angle_out(fin_tag[FTW-1 -: A]);
            o_elevation   <= angle_out(fin_tag[FTW-A-1 -: A]);
            o_parallactic <= angle_out(fin_tag[FTW-2*A-1 -: A]);
            o_sine_az     <= sin_az;
            o_cosine_az   <= cos_az;
            o_sine_el     <= fin_tag[63:32];
            o_cosine_el   <= fin_tag[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= fin_vld;
        end
    end

    assign o_out_valid = r_out_vld;

`ifndef NO_ASSERTIONS
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ha_vld == dec_vld) && (az_vld == pa_vld) && (el_vld == az_vld))
        else $error("parallel cordic lanes out of step");

    a_sin_el_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sine_el <= e2h_pkg::Q30_ONE) &&
                        (o_sine_el >= -e2h_pkg::Q30_ONE))
        else $error("sine of elevation beyond one");

    a_cos_el_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cosine_el <= e2h_pkg::Q30_ONE) && (o_cosine_el >= 0))
        else $error("cosine of elevation out of range");

    a_az_trig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sine_az <= e2h_pkg::Q30_ONE) &&
                        (o_sine_az >= -e2h_pkg::Q30_ONE) &&
                        (o_cosine_az <= e2h_pkg::Q30_ONE) &&
                        (o_cosine_az >= -e2h_pkg::Q30_ONE))
        else $error("azimuth trigonometry beyond one");
`endif

endmodule
`default_nettype wire
